FILE: design/signed_integer_to_radix_digits_core_macros.svh
// Assertion macros shared by the radix digits core.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SITRD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitrd: same-cycle property failed");
`define SITRD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitrd: next-cycle property failed");
`else
`define SITRD_ASSERT_IMP(name, ante, cons)
`define SITRD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: design/sitrd_pkg.sv
// Types, constants and helper functions of the radix digits core.
`timescale 1ns / 1ps
package sitrd_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int DIGIT_DEPTH = 32;
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int ALPHA_N     = 16;
  localparam int ALPHA_W     = ALPHA_N * CHAR_W;
  localparam int DIGIT_W     = 4;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int NIBBLES     = VALUE_W / DIGIT_W;
  localparam int NIB_CNT_W   = $clog2(NIBBLES);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET       = 5'd2;
  localparam logic [CFG_W-1:0]   DIGITS_LOW_RESET  = 64'h3130;
  localparam logic [CFG_W-1:0]   DIGITS_HIGH_RESET = 64'h0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_out_t;

  typedef struct packed {
    logic               digit_valid;
    logic [DIGIT_W-1:0] digit;
    logic               final_digit;
  } div_out_t;

  function automatic logic [CHAR_W-1:0] alpha_char(logic [ALPHA_W-1:0] alpha,
                                                   logic [DIGIT_W-1:0] k);
    return alpha[k * CHAR_W +: CHAR_W];
  endfunction

  // One nibble of long division: remainder in, quotient nibble and remainder out.
  function automatic logic [2*DIGIT_W-1:0] div_nibble(logic [DIGIT_W-1:0] rem,
                                                      logic [DIGIT_W-1:0] nib,
                                                      logic [RADIX_W-1:0] n);
    logic [RADIX_W:0]   acc;
    logic [DIGIT_W-1:0] q;
    acc = {2'b00, rem};
    q   = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      acc = {acc[RADIX_W-1:0], nib[i]};
      if (acc >= {1'b0, n}) begin
        acc  = acc - {1'b0, n};
        q[i] = 1'b1;
      end
    end
    return {q, acc[DIGIT_W-1:0]};
  endfunction

endpackage

FILE: design/signed_integer_to_radix_digits_core.sv
// Top level: converts a signed 32-bit value to text in a configured radix.
//
//   Channel   Signals                                   Direction
//   item      item_valid, item_ready, value             in
//   result    result_valid, result_ready, character, last  out
//   config    cfg_write, cfg_index, cfg_data            in
//
// The nibble-serial divider yields one digit per pass over the eight value nibbles.
// The alphabet check walks up to radix characters; a bad alphabet ends the item there.
// Characters leave at one per cycle from an output register; stalls hold the sequence.
// Reset is synchronous and restores the default binary alphabet.
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_core_macros.svh"
module signed_integer_to_radix_digits_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic signed [sitrd_pkg::VALUE_W-1:0] value,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [sitrd_pkg::CHAR_W-1:0]    character,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [sitrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sitrd_pkg::CFG_W-1:0]     cfg_data
);
  import sitrd_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [RADIX_W-1:0] radix;
  logic [CFG_W-1:0]   digits_low;
  logic [CFG_W-1:0]   digits_high;
  logic [ALPHA_W-1:0] alpha;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  idx_next;
  logic               accept;
  logic               out_free;
  logic               chk_start;
  logic               div_start;
  logic               ram_we;
  logic               load_out;
  logic [CHAR_W-1:0]  load_char;
  logic               load_last;
  logic [DIGIT_W-1:0] rd_data;
  chk_out_t           chk_o;
  div_out_t           div_o;

  assign alpha      = {digits_high, digits_low};
  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  sitrd_alpha_check u_check (
    .clk   (clk),
    .rst   (rst),
    .start (chk_start),
    .radix (radix),
    .alpha (alpha),
    .chk_o (chk_o)
  );

  sitrd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .radix (radix),
    .div_o (div_o)
  );

  sitrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (div_o.digit),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      digits_low  <= DIGITS_LOW_RESET;
      digits_high <= DIGITS_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:       radix       <= cfg_data[RADIX_W-1:0];
        REG_DIGITS_LOW:  digits_low  <= cfg_data;
        REG_DIGITS_HIGH: digits_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    chk_start  = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    load_char  = alpha_char(alpha, rd_data);
    load_last  = (idx == '0);
    case (state)
      S_IDLE: begin
        if (accept) begin
          chk_start  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_o.done) begin
          if (chk_o.ok) begin
            div_start  = 1'b1;
            cnt_next   = '0;
            state_next = S_DIV;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_o.digit_valid) begin
          ram_we   = 1'b1;
          cnt_next = cnt + CNT_W'(1);
          if (div_o.final_digit) begin
            idx_next   = cnt[ADDR_W-1:0];
            state_next = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg) begin
          state_next = S_EMIT;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_char  = CHAR_MINUS;
          load_last  = 1'b0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx - ADDR_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? $unsigned(-value) : $unsigned(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      character <= load_char;
      last      <= load_last;
    end
  end

  `SITRD_ASSERT_IMP(a_store_bound, (state == S_DIV) && div_o.digit_valid, cnt < CNT_W'(DIGIT_DEPTH))
  `SITRD_ASSERT_NEXT(a_emit_loads, (state == S_EMIT) && out_free, result_valid)
  `SITRD_ASSERT_NEXT(a_last_ends, (state == S_EMIT) && out_free && (idx == '0), (state == S_IDLE) && last)
  `SITRD_ASSERT_NEXT(a_bad_alpha, (state == S_CHECK) && chk_o.done && !chk_o.ok, state == S_IDLE)

endmodule

FILE: design/sitrd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module sitrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sitrd_alpha_check.sv
// Serial alphabet checker, one alphabet character per cycle.
`timescale 1ns / 1ps
module sitrd_alpha_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sitrd_pkg::RADIX_W-1:0]     radix,
  input  logic [sitrd_pkg::ALPHA_W-1:0]     alpha,
  output sitrd_pkg::chk_out_t               chk_o
);
  import sitrd_pkg::*;

  logic               busy;
  logic               bad;
  logic [DIGIT_W-1:0] idx;
  logic [CHAR_W-1:0]  char_cur;
  logic               char_bad;
  logic               dup;
  logic               range_bad;
  logic [RADIX_W-1:0] radix_m1;

  always_comb begin
    range_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    radix_m1  = radix - RADIX_W'(1);
    char_cur  = alpha_char(alpha, idx);
    char_bad  = (char_cur == CHAR_PLUS) || (char_cur == CHAR_MINUS) ||
                (char_cur < CHAR_LOW) || (char_cur > CHAR_HIGH);
    dup = 1'b0;
    for (int b = 0; b < ALPHA_N; b++) begin
      if ((DIGIT_W'(b) > idx) && (RADIX_W'(b) < radix) &&
          (alpha_char(alpha, DIGIT_W'(b)) == char_cur)) begin
        dup = 1'b1;
      end
    end
    chk_o.done = busy && (bad || char_bad || dup || (RADIX_W'(idx) == radix_m1));
    chk_o.ok   = !(bad || char_bad || dup);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bad  <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      bad  <= range_bad;
      idx  <= '0;
    end else if (busy) begin
      if (chk_o.done) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + DIGIT_W'(1);
      end
    end
  end

endmodule

FILE: design/sitrd_div.sv
// Nibble-serial divider that peels off one radix digit per pass.
`timescale 1ns / 1ps
module sitrd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sitrd_pkg::VALUE_W-1:0] mag,
  input  logic [sitrd_pkg::RADIX_W-1:0] radix,
  output sitrd_pkg::div_out_t           div_o
);
  import sitrd_pkg::*;

  logic                   busy;
  logic [NIB_CNT_W-1:0]   nib_cnt;
  logic [VALUE_W-1:0]     q;
  logic [DIGIT_W-1:0]     rem;
  logic [2*DIGIT_W-1:0]   step;
  logic [VALUE_W-1:0]     q_next;
  logic                   pass_end;

  always_comb begin
    step     = div_nibble(rem, q[VALUE_W-1 -: DIGIT_W], radix);
    q_next   = {q[VALUE_W-DIGIT_W-1:0], step[2*DIGIT_W-1:DIGIT_W]};
    pass_end = busy && (nib_cnt == NIB_CNT_W'(NIBBLES - 1));
    div_o.digit_valid = pass_end;
    div_o.digit       = step[DIGIT_W-1:0];
    div_o.final_digit = (q_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      nib_cnt <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      nib_cnt <= '0;
    end else if (busy) begin
      nib_cnt <= nib_cnt + NIB_CNT_W'(1);
      if (pass_end && div_o.final_digit) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= mag;
      rem <= '0;
    end else if (busy) begin
      q   <= q_next;
      rem <= pass_end ? '0 : step[DIGIT_W-1:0];
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the signed integer to radix digits core.
`timescale 1ns / 1ps

module tb_top;
  import sitrd_pkg::*;

  class radix_text_scoreboard;
    logic [RADIX_W-1:0] radix       = RADIX_RESET;
    logic [CFG_W-1:0]   digits_low  = DIGITS_LOW_RESET;
    logic [CFG_W-1:0]   digits_high = DIGITS_HIGH_RESET;
    logic [CHAR_W-1:0]  text_chars[$];
    logic               text_lasts[$];
    int                 errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_RADIX:       radix = data[RADIX_W-1:0];
        REG_DIGITS_LOW:  digits_low = data;
        REG_DIGITS_HIGH: digits_high = data;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] glyph(int k);
      logic [2*CFG_W-1:0] alpha;
      alpha = {digits_high, digits_low};
      return alpha[k*CHAR_W +: CHAR_W];
    endfunction

    function bit alphabet_valid();
      logic [CHAR_W-1:0] c;
      if (radix < 2 || radix > MAX_RADIX) return 0;
      for (int a = 0; a < radix; a++) begin
        c = glyph(a);
        if (c == CHAR_PLUS || c == CHAR_MINUS) return 0;
        if (c < CHAR_LOW || c > CHAR_HIGH) return 0;
        for (int b = a + 1; b < radix; b++)
          if (glyph(b) == c) return 0;
      end
      return 1;
    endfunction

    // Works out the characters of one accepted value and queues them; none for a bad alphabet.
    function void predict_text(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] rem;
      logic [DIGIT_W-1:0] digs [DIGIT_DEPTH];
      int                 cnt;
      if (!alphabet_valid()) return;
      mag = v;
      if (mag[VALUE_W-1]) begin
        mag = -mag;
        text_chars.push_back(CHAR_MINUS);
        text_lasts.push_back(1'b0);
      end
      cnt = 0;
      do begin
        rem = mag % radix;
        digs[cnt] = rem[DIGIT_W-1:0];
        cnt++;
        mag = mag / radix;
      end while (mag != 0 && cnt < DIGIT_DEPTH);
      for (int k = cnt - 1; k >= 0; k--) begin
        text_chars.push_back(glyph(digs[k]));
        text_lasts.push_back(k == 0);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] c, logic l);
      logic [CHAR_W-1:0] want_c;
      logic              want_l;
      if (text_chars.size() == 0) begin
        $display("%0t: unexpected transaction, character %h last %b", $time, c, l);
        errors++;
        return;
      end
      want_c = text_chars.pop_front();
      want_l = text_lasts.pop_front();
      if (c !== want_c) begin
        $display("%0t: character expected %h, got %h", $time, want_c, c);
        errors++;
      end
      if (l !== want_l) begin
        $display("%0t: last expected %b, got %b", $time, want_l, l);
        errors++;
      end
    endfunction

    function int pending();
      return text_chars.size();
    endfunction
  endclass

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS  = 130;
  localparam int SETTLE_CYCLES = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam logic [2*CFG_W-1:0] HEX_ALPHABET = {64'h4645444342413938, 64'h3736353433323130};

  typedef enum int {
    BAD_RADIX_LOW,
    BAD_RADIX_HIGH,
    BAD_PLUS,
    BAD_MINUS,
    BAD_CTRL,
    BAD_HIGH_CHAR,
    BAD_DUP
  } flaw_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [CHAR_W-1:0]         character;
  logic                      last;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  radix_text_scoreboard sb;
  int send_gap_pct   = 8;
  int recv_stall_pct = 62;
  int quiet_cycles   = 0;

  signed_integer_to_radix_digits_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .value(value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .character(character),
    .last(last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_char(character, last);
    end
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("signed_integer_to_radix_digits_core: mismatch");
      $finish;
    end
  end

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.predict_text(v);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(input logic [RADIX_W-1:0] r, input logic [2*CFG_W-1:0] alpha);
    logic [CFG_W-1:0] radix_word;
    radix_word = {$urandom, $urandom};
    radix_word[RADIX_W-1:0] = r;
    cfg_write <= 1'b1;
    put_reg(REG_RADIX, radix_word);
    put_reg(REG_DIGITS_LOW, alpha[CFG_W-1:0]);
    put_reg(REG_DIGITS_HIGH, alpha[2*CFG_W-1:CFG_W]);
    put_reg(REG_SPARE, {$urandom, $urandom});
    cfg_write <= 1'b0;
  endtask

  function automatic logic [2*CFG_W-1:0] pick_alphabet(int n);
    logic [2*CFG_W-1:0] a;
    logic [CHAR_W-1:0]  c;
    bit                 used [256];
    a = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      do c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
      while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
      used[c] = 1'b1;
      a[i*CHAR_W +: CHAR_W] = c;
    end
    return a;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      5, 6, 7: v = $urandom_range(0, 300);
      8:       v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9:       v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    if (v > 0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic load_flawed(input flaw_t kind);
    int                 n;
    int                 s;
    int                 t;
    logic [RADIX_W-1:0] r;
    logic [2*CFG_W-1:0] a;
    n = $urandom_range(2, MAX_RADIX);
    a = pick_alphabet(n);
    r = RADIX_W'(n);
    s = $urandom_range(0, n - 1);
    case (kind)
      BAD_RADIX_LOW:  r = RADIX_W'($urandom_range(0, 1));
      BAD_RADIX_HIGH: r = RADIX_W'($urandom_range(MAX_RADIX + 1, 31));
      BAD_PLUS:       a[s*CHAR_W +: CHAR_W] = CHAR_PLUS;
      BAD_MINUS:      a[s*CHAR_W +: CHAR_W] = CHAR_MINUS;
      BAD_CTRL:       a[s*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(0, CHAR_LOW - 1));
      BAD_HIGH_CHAR:  a[s*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
      BAD_DUP: begin
        t = (s + $urandom_range(1, n - 1)) % n;
        a[s*CHAR_W +: CHAR_W] = a[t*CHAR_W +: CHAR_W];
      end
      default: ;
    endcase
    load_config(r, a);
  endtask

  task automatic update_idling(input int counted);
    if (counted < RANDOM_ITEMS / 3) begin
      send_gap_pct   = 8;
      recv_stall_pct = 62;
    end else if (counted < 2 * RANDOM_ITEMS / 3) begin
      send_gap_pct   = 62;
      recv_stall_pct = 8;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endtask

  initial begin
    int                 counted;
    int                 burst;
    logic [RADIX_W-1:0] r;
    sb = new;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);

    drain();
    load_config(RADIX_W'(MAX_RADIX), HEX_ALPHABET);
    send_value(32'sd0);
    send_value(32'sd15);
    send_value(-32'sd16);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh89AB_CDEF);

    drain();
    load_config(5'd0, HEX_ALPHABET);
    send_value(32'sd5);
    drain();
    load_config(5'd1, HEX_ALPHABET);
    send_value(-32'sd5);
    drain();
    load_config(5'd31, HEX_ALPHABET);
    send_value(32'sd77);
    for (int k = BAD_PLUS; k <= BAD_DUP; k++) begin
      drain();
      load_flawed(flaw_t'(k));
      send_value(pick_value());
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 9) == 0) begin
        load_flawed(flaw_t'($urandom_range(BAD_RADIX_LOW, BAD_DUP)));
        repeat ($urandom_range(1, 3)) send_value(pick_value());
      end else begin
        case ($urandom_range(0, 3))
          0:       r = 5'd2;
          1:       r = RADIX_W'(MAX_RADIX);
          default: r = RADIX_W'($urandom_range(2, MAX_RADIX));
        endcase
        load_config(r, pick_alphabet(r));
        burst = $urandom_range(6, 20);
        repeat (burst) begin
          update_idling(counted);
          send_value(pick_value());
          counted++;
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("signed_integer_to_radix_digits_core: match");
    end else begin
      $display("signed_integer_to_radix_digits_core: mismatch");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/sitrd_pkg.sv
design/sitrd_ram.sv
design/sitrd_alpha_check.sv
design/sitrd_div.sv
design/signed_integer_to_radix_digits_core.sv
tb/tb_top.sv
